// ===== rtl/core/io_request_priority_queue_core_defines.svh =====
// Assertion macros used by the priority queue RTL.
`ifndef IO_REQUEST_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define IO_REQUEST_PRIORITY_QUEUE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every edge outside reset.
`define IORPQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("iorpq check failed");
// Condition must never be true outside reset.
`define IORPQ_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("iorpq forbidden condition");
`else
`define IORPQ_ASSERT(lbl, clk, rst, prop)
`define IORPQ_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/core/iorpq_pkg.sv =====
// Codes and constants of the I/O request priority queue.
`timescale 1ns / 1ps
`default_nettype none
package iorpq_pkg;
  localparam int unsigned KEY_W = 32;
  localparam logic [KEY_W-1:0] KEY_BONUS = 32'd128;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_DISPATCH = 3'd1;
  localparam logic [2:0] OP_MERGE    = 3'd2;
  localparam logic [2:0] OP_FORMER   = 3'd3;
  localparam logic [2:0] OP_LATTER   = 3'd4;

  localparam logic [1:0] ST_OK_ID = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/io_request_priority_queue_core.sv =====
// Top level of the I/O request priority queue.
`timescale 1ns / 1ps
`default_nettype none
`include "io_request_priority_queue_core_defines.svh"
// Bounded priority queue of request ids kept as a key-sorted table in one
// memory (one write port, one read port, registered read). Valid
// entries always fill addresses 0..count-1 in ascending key order; equal keys
// keep arrival order. One command beat in, exactly one result beat out.
// Per entry touched, the memory is read and the read data checked. Add walks
// down from the last entry, moving each entry with a larger key up one slot,
// then writes the new entry; a full or empty table skips the walk. Dispatch
// and merge scan every entry and close the gap behind the removed one. Former
// and latter scan from slot 0 up to the id, latter also reading the next one;
// an absent id scans the whole table. An empty table or unknown command goes
// straight to the result.
// The result sits in an output register; the next command beat is taken
// while that result waits, and only the following completion stalls on it.
// No clearing pass is needed after reset.
module io_request_priority_queue_core
  import iorpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned ID_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] request_id,
  input  wire logic [63:0] vruntime,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      result_id,
  output logic [1:0]       status
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_W + ID_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_CK, S_INS_PUT, S_SCAN_RD, S_SCAN_CK, S_DONE
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  logic [2:0]        op_r;
  logic [ID_BITS-1:0] id_r;
  logic [ID_BITS-1:0] prev_id;
  logic [KEY_W-1:0]  key_r;
  logic              found;
  logic [KEY_W-1:0]  arrival_count;
  logic [63:0]       runtime_max;
  logic [ID_BITS-1:0] res_id_r;
  logic [1:0]        res_st_r;

  // Request id masked to ID_BITS, and stored ids widened back for output.
  logic [ID_BITS+15:0] id_ext;
  logic [ID_BITS-1:0]  id_in;
  assign id_ext = {{ID_BITS{1'b0}}, request_id};
  assign id_in  = id_ext[ID_BITS-1:0];

  function automatic logic [15:0] to_out(input logic [ID_BITS-1:0] v);
    logic [ID_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  // Add path: new maximum and key computed at accept.
  logic [KEY_W-1:0] arrival_next;
  logic [63:0]      runtime_max_next;
  logic [KEY_W-1:0] key_next;
  assign arrival_next     = arrival_count + 1'b1;
  assign runtime_max_next = (vruntime > runtime_max) ? vruntime : runtime_max;
  assign key_next = (runtime_max_next != 64'd0 && vruntime == runtime_max_next)
                    ? arrival_next + KEY_BONUS : arrival_next;

  // Memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [ID_BITS-1:0] rd_id;
  assign rd_key = mem_rdata[EW-1:ID_BITS];
  assign rd_id  = mem_rdata[ID_BITS-1:0];

  iorpq_ram #(.DEPTH(CAPACITY), .WIDTH(EW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  logic last;
  logic hit;
  logic take_now;
  logic is_pop;
  assign last     = (CW'(idx) == CW'(count - 1'b1));
  assign hit      = (rd_id == id_r);
  assign is_pop   = (op_r == OP_DISPATCH) || (op_r == OP_MERGE);
  assign take_now = !found && ((op_r == OP_DISPATCH) ? (idx == '0) : hit);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = mem_rdata;
    mem_raddr = idx;
    case (state)
      S_IDLE: begin
        // empty table add writes straight to slot 0
        mem_waddr = '0;
        mem_wdata = {key_next, id_in};
        mem_we    = in_valid && operation == OP_ADD && count == '0;
      end
      S_INS_CK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx + 1'b1);
        mem_wdata = (rd_key <= key_r) ? {key_r, id_r} : mem_rdata;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {key_r, id_r};
      end
      S_SCAN_CK: begin
        // close the gap behind a removed entry
        mem_we    = is_pop && found;
        mem_waddr = AW'(idx - 1'b1);
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      arrival_count <= '0;
      runtime_max   <= '0;
      out_valid     <= 1'b0;
      found         <= 1'b0;
    end else begin
      // S_DONE drives out_valid itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= operation;
            id_r     <= id_in;
            key_r    <= key_next;
            found    <= 1'b0;
            res_id_r <= '0;
            res_st_r <= ST_MISS;
            idx      <= '0;
            state    <= S_DONE;
            if (operation == OP_ADD) begin
              arrival_count <= arrival_next;
              runtime_max   <= runtime_max_next;
              if (count == CW'(CAPACITY)) begin
                res_st_r <= ST_FULL;
              end else if (count == '0) begin
                count    <= CW'(1);
                res_st_r <= ST_OK;
              end else begin
                idx   <= AW'(count - 1'b1);
                state <= S_INS_RD;
              end
            end else if ((operation == OP_DISPATCH || operation == OP_MERGE ||
                          operation == OP_FORMER || operation == OP_LATTER) &&
                         count != '0) begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_INS_RD: state <= S_INS_CK;
        S_INS_CK: begin
          if (rd_key <= key_r) begin
            count    <= count + 1'b1;
            res_st_r <= ST_OK;
            state    <= S_DONE;
          end else if (idx == '0) begin
            state <= S_INS_PUT;
          end else begin
            idx   <= idx - 1'b1;
            state <= S_INS_RD;
          end
        end
        S_INS_PUT: begin
          count    <= count + 1'b1;
          res_st_r <= ST_OK;
          state    <= S_DONE;
        end
        S_SCAN_RD: state <= S_SCAN_CK;
        S_SCAN_CK: begin
          state <= S_SCAN_RD;
          idx   <= AW'(idx + 1'b1);
          if (is_pop) begin
            if (take_now) begin
              found    <= 1'b1;
              res_id_r <= (op_r == OP_DISPATCH) ? rd_id : '0;
            end
            if (last) begin
              state <= S_DONE;
              if (found || take_now) begin
                count    <= count - 1'b1;
                res_st_r <= (op_r == OP_DISPATCH) ? ST_OK_ID : ST_OK;
              end
            end
          end else if (op_r == OP_FORMER) begin
            prev_id <= rd_id;
            if (hit) begin
              state <= S_DONE;
              if (idx != '0) begin
                res_id_r <= prev_id;
                res_st_r <= ST_OK_ID;
              end
            end else if (last) begin
              state <= S_DONE;
            end
          end else begin
            // latter neighbor
            if (found) begin
              res_id_r <= rd_id;
              res_st_r <= ST_OK_ID;
              state    <= S_DONE;
            end else begin
              found <= hit;
              if (last) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            result_id <= to_out(res_id_r);
            status    <= res_st_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IORPQ_NEVER(a_count_bound, clk, rst, count > CW'(CAPACITY))
  `IORPQ_NEVER(a_we_busy, clk, rst, mem_we && state == S_DONE)
  `IORPQ_ASSERT(a_count_step, clk, rst,
                (count == $past(count)) || (count == $past(count) + 1'b1) ||
                (count + 1'b1 == $past(count)))
  `IORPQ_ASSERT(a_id_status, clk, rst, (out_valid && status != ST_OK_ID) |-> (result_id == 16'd0))
endmodule
`default_nettype wire

// ===== rtl/core/iorpq_ram.sv =====
// Single-port-read, single-port-write entry memory with registered read.
`timescale 1ns / 1ps
`default_nettype none
module iorpq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
